>>> src/smt_pkg.sv
// Shared types and constants for the sorted multiset table.
package smt_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int COUNT_W  = 5;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic                    load;
    action_t                 action;
    logic signed [VAL_W-1:0] value;
    logic                    full;
    logic                    hit;
  } cmd_t;

endpackage

>>> src/sorted_multiset_table.sv
// Top level of the sorted multiset table: a chain of compare-and-shift cells.
// The result of an accepted item is registered in the output register.
// Throughput: one item per cycle while the output register is taken; every cell compares and shifts in parallel.
// The input is held only while the output register is full and not taken.
// Reset clears the entry count and the output valid; cell contents are not reset.
module sorted_multiset_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // item_value[31:0]
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status[1:0], found[2], entry_count[7:3], is_empty[8], zero
);

  localparam int N = smt_pkg::CAPACITY;

  smt_pkg::cmd_t                     cmd;
  logic [smt_pkg::CNT_W-1:0]         count;
  logic [smt_pkg::CNT_W-1:0]         count_next;
  logic signed [smt_pkg::VAL_W-1:0]  entries [N];
  logic [N-1:0]                      lt_vec;
  logic [N-1:0]                      eq_vec;
  logic [N-1:0]                      valid_vec;
  smt_pkg::status_t                  status_next;
  logic                              found_next;
  smt_pkg::status_t                  status;
  logic                              found;
  logic [smt_pkg::CNT_W+smt_pkg::COUNT_W-1:0] count_wide;

  assign s_tready = !m_tvalid || m_tready;

  assign cmd.load   = s_tvalid && s_tready;
  assign cmd.action = smt_pkg::action_t'(s_tuser);
  assign cmd.value  = s_tdata;
  assign cmd.full   = (count == smt_pkg::CNT_W'(N));
  assign cmd.hit    = |eq_vec;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign valid_vec[i] = smt_pkg::CNT_W'(i) < count;
    if (i == 0) begin : g_head
      if (N > 1) begin : g_more
        smt_cell u_cell (
          .clk        (clk),
          .cmd        (cmd),
          .cell_valid (valid_vec[i]),
          .left_lt    (1'b0),
          .left_entry (cmd.value),
          .right_entry(entries[i+1]),
          .entry      (entries[i]),
          .lt         (lt_vec[i]),
          .eq         (eq_vec[i])
        );
      end
    end else if (i == N - 1) begin : g_tail
      smt_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .cell_valid (valid_vec[i]),
        .left_lt    (lt_vec[i-1]),
        .left_entry (entries[i-1]),
        .right_entry(entries[i]),
        .entry      (entries[i]),
        .lt         (lt_vec[i]),
        .eq         (eq_vec[i])
      );
    end else begin : g_mid
      smt_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .cell_valid (valid_vec[i]),
        .left_lt    (lt_vec[i-1]),
        .left_entry (entries[i-1]),
        .right_entry(entries[i+1]),
        .entry      (entries[i]),
        .lt         (lt_vec[i]),
        .eq         (eq_vec[i])
      );
    end
  end

  always_comb begin
    count_next  = count;
    status_next = smt_pkg::ST_DONE;
    found_next  = 1'b0;
    case (cmd.action)
      smt_pkg::ACT_INSERT: begin
        if (cmd.full) begin
          status_next = smt_pkg::ST_FULL;
        end else begin
          count_next = count + smt_pkg::CNT_W'(1);
        end
      end
      smt_pkg::ACT_REMOVE: begin
        if (cmd.hit) begin
          found_next = 1'b1;
          count_next = count - smt_pkg::CNT_W'(1);
        end else begin
          status_next = smt_pkg::ST_NOT_FOUND;
        end
      end
      smt_pkg::ACT_SEARCH: begin
        if (cmd.hit) begin
          found_next = 1'b1;
        end else begin
          status_next = smt_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.load) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status <= status_next;
      found  <= found_next;
    end
  end

  assign count_wide = {{smt_pkg::COUNT_W{1'b0}}, count};

  assign m_tdata = {7'd0, (count == '0), count_wide[smt_pkg::COUNT_W-1:0], found, status};

endmodule

>>> src/smt_cell.sv
// One storage cell of the sorted chain: holds one entry and shifts with its neighbors.
module smt_cell (
  input  logic                            clk,
  input  smt_pkg::cmd_t                   cmd,
  input  logic                            cell_valid,
  input  logic                            left_lt,
  input  logic signed [smt_pkg::VAL_W-1:0] left_entry,
  input  logic signed [smt_pkg::VAL_W-1:0] right_entry,
  output logic signed [smt_pkg::VAL_W-1:0] entry,
  output logic                            lt,
  output logic                            eq
);

  logic signed [smt_pkg::VAL_W-1:0] entry_next;
  logic                             write_en;

  assign lt = cell_valid && (entry < cmd.value);
  assign eq = cell_valid && (entry == cmd.value);

  // The chain is sorted, so cells below the target position are exactly those
  // that hold a smaller value. An insert opens a gap at the first cell that is
  // not smaller; a remove closes the gap at that same cell.
  always_comb begin
    entry_next = entry;
    write_en   = 1'b0;
    case (cmd.action)
      smt_pkg::ACT_INSERT: begin
        if (!cmd.full && !lt) begin
          write_en   = 1'b1;
          entry_next = left_lt ? cmd.value : left_entry;
        end
      end
      smt_pkg::ACT_REMOVE: begin
        if (cmd.hit && !lt) begin
          write_en   = 1'b1;
          entry_next = right_entry;
        end
      end
      default: begin
        write_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load && write_en) begin
      entry <= entry_next;
    end
  end

endmodule

>>> sim/sorted_multiset_table_tb.sv
// Self-checking testbench for the sorted multiset table with a scoreboard and random handshakes.
module sorted_multiset_table_tb;

  typedef struct packed {
    smt_pkg::status_t status;
    logic             found;
    logic [4:0]       count;
    logic             is_empty;
  } table_result_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

  class table_scoreboard;
    logic signed [smt_pkg::VAL_W-1:0] entries [smt_pkg::CAPACITY];
    int                               fill;
    table_result_t                    expected_q[$];
    int                               errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int first_equal(logic signed [smt_pkg::VAL_W-1:0] v);
      for (int i = 0; i < fill; i++) begin
        if (entries[i] == v) return i;
      end
      return fill;
    endfunction

    function logic [31:0] pick_stored();
      if (fill == 0) return $urandom();
      return entries[$urandom_range(0, fill - 1)];
    endfunction

    function void note_item(smt_pkg::action_t act, logic signed [smt_pkg::VAL_W-1:0] v);
      table_result_t r;
      int pos;
      r.status = smt_pkg::ST_DONE;
      r.found  = 1'b0;
      case (act)
        smt_pkg::ACT_INSERT: begin
          if (fill >= smt_pkg::CAPACITY) begin
            r.status = smt_pkg::ST_FULL;
          end else begin
            pos = 0;
            while (pos < fill && entries[pos] < v) pos++;
            for (int i = fill; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = v;
            fill++;
          end
        end
        smt_pkg::ACT_REMOVE: begin
          pos = first_equal(v);
          if (pos < fill) begin
            for (int i = pos; i + 1 < fill; i++) entries[i] = entries[i+1];
            fill--;
            r.found = 1'b1;
          end else begin
            r.status = smt_pkg::ST_NOT_FOUND;
          end
        end
        smt_pkg::ACT_SEARCH: begin
          if (first_equal(v) < fill) r.found = 1'b1;
          else r.status = smt_pkg::ST_NOT_FOUND;
        end
        default: begin
          fill = 0;
        end
      endcase
      r.count    = 5'(fill);
      r.is_empty = (fill == 0);
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [15:0] d);
      table_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, d);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (d[1:0] !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, d[1:0]);
        errors++;
      end
      if (d[2] !== want.found) begin
        $display("%0t: found expected %0b actual %0b", $time, want.found, d[2]);
        errors++;
      end
      if (d[7:3] !== want.count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, want.count, d[7:3]);
        errors++;
      end
      if (d[8] !== want.is_empty) begin
        $display("%0t: is_empty expected %0b actual %0b", $time, want.is_empty, d[8]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  table_scoreboard board = new();
  int              gap_max;
  int              stall_max;

  sorted_multiset_table u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_item(smt_pkg::action_t act, logic [31:0] val);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_item(act, val);
  endtask

  task automatic send_random(phase_t ph);
    int               roll;
    int               ins_lim;
    int               rem_lim;
    int               srch_lim;
    smt_pkg::action_t act;
    logic [31:0]      val;
    roll = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        ins_lim = 75; rem_lim = 88; srch_lim = 99;
      end
      PH_DRAIN: begin
        ins_lim = 15; rem_lim = 75; srch_lim = 97;
      end
      default: begin
        ins_lim = 40; rem_lim = 70; srch_lim = 97;
      end
    endcase
    if (roll < ins_lim) act = smt_pkg::ACT_INSERT;
    else if (roll < rem_lim) act = smt_pkg::ACT_REMOVE;
    else if (roll < srch_lim) act = smt_pkg::ACT_SEARCH;
    else act = smt_pkg::ACT_CLEAR;
    roll = $urandom_range(0, 99);
    if (roll < 55) val = 32'($urandom_range(0, 8)) - 32'd4;
    else if (roll < 85) val = board.pick_stored();
    else val = $urandom();
    send_item(act, val);
  endtask

  initial begin
    wait (!rst);
    forever begin
      int stall;
      stall = $urandom_range(0, stall_max);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      board.check_result(m_tdata);
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL sorted_multiset_table");
    $finish;
  end

  initial begin
    phase_t ph;
    gap_max   = 3;
    stall_max = 3;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(smt_pkg::ACT_SEARCH, 32'd0);
    send_item(smt_pkg::ACT_REMOVE, 32'd5);
    send_item(smt_pkg::ACT_INSERT, 32'h7FFF_FFFF);
    send_item(smt_pkg::ACT_INSERT, 32'h8000_0000);
    send_item(smt_pkg::ACT_INSERT, 32'd0);
    send_item(smt_pkg::ACT_INSERT, 32'hFFFF_FFFF);
    send_item(smt_pkg::ACT_INSERT, 32'd0);
    send_item(smt_pkg::ACT_INSERT, 32'd0);
    send_item(smt_pkg::ACT_SEARCH, 32'd0);
    send_item(smt_pkg::ACT_SEARCH, 32'd1);
    send_item(smt_pkg::ACT_REMOVE, 32'd0);
    send_item(smt_pkg::ACT_SEARCH, 32'd0);
    send_item(smt_pkg::ACT_REMOVE, 32'd42);
    send_item(smt_pkg::ACT_REMOVE, 32'hFFFF_FFFF);
    send_item(smt_pkg::ACT_SEARCH, 32'h8000_0000);
    send_item(smt_pkg::ACT_REMOVE, 32'h8000_0000);
    send_item(smt_pkg::ACT_REMOVE, 32'h7FFF_FFFF);
    send_item(smt_pkg::ACT_INSERT, 32'h5555_5555);
    send_item(smt_pkg::ACT_INSERT, 32'hAAAA_AAAA);
    send_item(smt_pkg::ACT_CLEAR, 32'hFFFF_FFFF);
    send_item(smt_pkg::ACT_SEARCH, 32'd0);
    send_item(smt_pkg::ACT_INSERT, 32'd7);
    send_item(smt_pkg::ACT_REMOVE, 32'd7);
    send_item(smt_pkg::ACT_CLEAR, 32'd0);

    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);

    for (int p = 0; p < 25; p++) begin
      if (p == 0) ph = PH_FILL;
      else ph = phase_t'($urandom_range(0, 2));
      gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 10;
      stall_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
      for (int k = 0; k < 50; k++) send_random(ph);
      if ($urandom_range(0, 3) == 0) begin
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
      end
    end

    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS sorted_multiset_table");
    end else begin
      $display("FAIL sorted_multiset_table");
    end
    $finish;
  end

endmodule

>>> sim.f
src/smt_pkg.sv
src/smt_cell.sv
src/sorted_multiset_table.sv
sim/sorted_multiset_table_tb.sv
